// ===== rtl/ohc_pkg.sv =====
`default_nettype none
package ohc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 16;
	localparam int GAIN_BITS   = 10;
	localparam int ACC_BITS    = 40;
	localparam int TAPS        = 22;
	localparam int IN_DEPTH    = 6;

	// clip level, 0.6 of full scale
	localparam logic signed [38:0] CLIP_POS = 39'sd5033165;
	localparam logic signed [38:0] CLIP_NEG = -39'sd5033165;
	localparam logic signed [39:0] SAT_POS  = 40'sd8388607;
	localparam logic signed [39:0] SAT_NEG  = -40'sd8388608;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRX,
		ST_UP_ISSUE,
		ST_UP_DRAIN,
		ST_GAIN,
		ST_CLIP,
		ST_DN_ISSUE,
		ST_DN_DRAIN,
		ST_RES,
		ST_DONE
	} ohc_state_t;

	// symmetric 22-tap lowpass, q1.15
	function automatic logic signed [COEF_BITS-1:0] lp_coef(input logic [4:0] k);
		logic [4:0] f;
		logic signed [COEF_BITS-1:0] c;
		f = (k < 5'd11) ? k : 5'd21 - k;
		unique case (f)
			5'd0:    c = -16'sd3;
			5'd1:    c = 16'sd13;
			5'd2:    c = 16'sd46;
			5'd3:    c = -16'sd111;
			5'd4:    c = -16'sd239;
			5'd5:    c = 16'sd455;
			5'd6:    c = 16'sd809;
			5'd7:    c = -16'sd1386;
			5'd8:    c = -16'sd2389;
			5'd9:    c = 16'sd4561;
			5'd10:   c = 16'sd14628;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/oversampled_hard_clipper.sv =====
// each frame is processed left channel then right, then loaded into the result register
// pacing: one frame at a time, the next taken once the result is loaded; the work is
//   done by the single multiply-accumulate unit reading the history memories one tap
//   per cycle (24 upsampling and 22 decimation tap slots, pipeline drain, gain and clip
//   steps per channel); a stalled result holds the frame
// reset: asynchronous, active low; a clearing pass zeroes the history memories after
//   reset, input is not taken during it; gain resets to 10.0
`default_nettype none
module oversampled_hard_clipper
	import ohc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data,      // drive_gain
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // in_left [23:0], in_right [47:24]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // out_left [23:0], out_right [47:24]
);

	ohc_state_t state_q, state_d;

	logic                       ch_q;
	logic [1:0]                 ph_q;
	logic [4:0]                 tap_q;
	logic [2:0]                 ip_q;
	logic [4:0]                 cp_q;
	logic [5:0]                 clr_q;
	logic [47:0]                din_q;
	logic [23:0]                res0_q, res1_q;
	logic [47:0]                out_q;
	logic                       out_valid_q;
	logic [GAIN_BITS-1:0]       gain_q;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [38:0]         gprod_q;

	// mac pipeline
	logic signed [COEF_BITS-1:0] coef_s1;
	logic                        v_s1, src_s1;
	logic signed [ACC_BITS-1:0]  prod_s2;
	logic                        v_s2;

	// memories
	logic [23:0] in_mem [2*IN_DEPTH];
	logic [23:0] cl_mem [2*TAPS];
	logic [23:0] in_rdata_q, cl_rdata_q;

	logic        in_we, cl_we, issue, src;
	logic [3:0]  in_waddr;
	logic [5:0]  cl_waddr;
	logic [23:0] in_wdata, cl_wdata;
	logic [4:0]  coef_idx;

	// address arithmetic
	logic [23:0] x_sel;
	logic [4:0]  up_k;
	logic        up_ok;
	logic [3:0]  in_t, in_rel, in_addr;
	logic [5:0]  cw_t, cw_rel, cl_waddr_w;
	logic [5:0]  cr_t, cr_rel, cl_raddr;
	logic [5:0]  cp_adv;

	// arithmetic
	logic signed [39:0] u_full, r_full;
	logic signed [27:0] u_w;
	logic signed [38:0] z_full;
	logic [23:0]        z_w, r_w;
	logic               out_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign x_sel = ch_q ? din_q[47:24] : din_q[23:0];
	assign up_k  = {3'b000, ph_q} + {tap_q[2:0], 2'b00};
	assign up_ok = (up_k < 5'd22);

	// input ring, newest at ip_q
	assign in_t    = {1'b0, ip_q} + 4'd6 - {1'b0, tap_q[2:0]};
	assign in_rel  = (in_t >= 4'd6) ? in_t - 4'd6 : in_t;
	assign in_addr = (ch_q ? 4'd6 : 4'd0) + in_rel;

	// clipped ring, phase-0 value of this frame at cp_q
	assign cw_t       = {1'b0, cp_q} + {4'b0000, ph_q};
	assign cw_rel     = (cw_t >= 6'd22) ? cw_t - 6'd22 : cw_t;
	assign cl_waddr_w = (ch_q ? 6'd22 : 6'd0) + cw_rel;
	assign cr_t       = {1'b0, cp_q} + 6'd22 - {1'b0, tap_q};
	assign cr_rel     = (cr_t >= 6'd22) ? cr_t - 6'd22 : cr_t;
	assign cl_raddr   = (ch_q ? 6'd22 : 6'd0) + cr_rel;
	assign cp_adv     = ({1'b0, cp_q} + 6'd4 >= 6'd22) ? {1'b0, cp_q} + 6'd4 - 6'd22
	                                                   : {1'b0, cp_q} + 6'd4;

	// upsampled value, then driven and clipped value
	assign u_full = (acc_q + 40'sd4096) >>> 13;
	assign u_w    = u_full[27:0];
	assign z_full = (gprod_q + 39'sd8) >>> 4;
	always_comb begin
		if (z_full > CLIP_POS) begin
			z_w = CLIP_POS[23:0];
		end else if (z_full < CLIP_NEG) begin
			z_w = CLIP_NEG[23:0];
		end else begin
			z_w = z_full[23:0];
		end
	end

	// decimated output with saturation
	assign r_full = (acc_q + 40'sd16384) >>> 15;
	always_comb begin
		if (r_full > SAT_POS) begin
			r_w = SAT_POS[23:0];
		end else if (r_full < SAT_NEG) begin
			r_w = SAT_NEG[23:0];
		end else begin
			r_w = r_full[23:0];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (clr_q == 6'd43) state_d = ST_IDLE;
			ST_IDLE:     if (s_axis_tvalid) state_d = ST_WRX;
			ST_WRX:      state_d = ST_UP_ISSUE;
			ST_UP_ISSUE: if (tap_q == 5'd5) state_d = ST_UP_DRAIN;
			ST_UP_DRAIN: if (!v_s1 && !v_s2) state_d = ST_GAIN;
			ST_GAIN:     state_d = ST_CLIP;
			ST_CLIP: begin
				if (ph_q == 2'd0) begin
					state_d = ST_DN_ISSUE;
				end else if (ph_q == 2'd3) begin
					state_d = ch_q ? ST_DONE : ST_WRX;
				end else begin
					state_d = ST_UP_ISSUE;
				end
			end
			ST_DN_ISSUE: if (tap_q == 5'd21) state_d = ST_DN_DRAIN;
			ST_DN_DRAIN: if (!v_s1 && !v_s2) state_d = ST_RES;
			ST_RES:      state_d = ST_UP_ISSUE;
			ST_DONE:     if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// memory and mac controls
	always_comb begin
		in_we    = 1'b0;
		in_waddr = in_addr;
		in_wdata = x_sel;
		cl_we    = 1'b0;
		cl_waddr = cl_waddr_w;
		cl_wdata = z_w;
		issue    = 1'b0;
		src      = 1'b0;
		coef_idx = up_k;
		unique case (state_q)
			ST_CLEAR: begin
				in_we    = (clr_q < 6'd12);
				in_waddr = clr_q[3:0];
				in_wdata = '0;
				cl_we    = 1'b1;
				cl_waddr = clr_q;
				cl_wdata = '0;
			end
			ST_WRX:      in_we = 1'b1;
			ST_UP_ISSUE: issue = up_ok;
			ST_CLIP:     cl_we = 1'b1;
			ST_DN_ISSUE: begin
				issue    = 1'b1;
				src      = 1'b1;
				coef_idx = tap_q;
			end
			default: ;
		endcase
	end

	// history memories
	always_ff @(posedge clk) begin
		if (in_we) begin
			in_mem[in_waddr] <= in_wdata;
		end
		in_rdata_q <= in_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (cl_we) begin
			cl_mem[cl_waddr] <= cl_wdata;
		end
		cl_rdata_q <= cl_mem[cl_raddr];
	end

	// mac datapath
	always_ff @(posedge clk) begin
		coef_s1 <= lp_coef(coef_idx);
		src_s1  <= src;
		prod_s2 <= (src_s1 ? $signed(cl_rdata_q) : $signed(in_rdata_q)) * coef_s1;
		gprod_q <= u_w * $signed({1'b0, gain_q});
		if (state_q == ST_WRX || state_q == ST_CLIP || state_q == ST_RES) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			din_q <= s_axis_tdata;
		end
		if (state_q == ST_RES) begin
			if (ch_q) begin
				res1_q <= r_w;
			end else begin
				res0_q <= r_w;
			end
		end
		if (out_load) begin
			out_q <= {res1_q, res0_q};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ch_q        <= 1'b0;
			ph_q        <= '0;
			tap_q       <= '0;
			ip_q        <= '0;
			cp_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			gain_q      <= 10'd160;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (cfg_valid && cfg_ready) begin
				gain_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 6'd1;
			end
			if (state_q == ST_UP_ISSUE || state_q == ST_DN_ISSUE) begin
				tap_q <= tap_q + 5'd1;
			end else begin
				tap_q <= '0;
			end
			if (state_q == ST_CLIP) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					ch_q <= ~ch_q;
				end
			end
			// frame done: advance both rings
			if (out_load) begin
				ip_q <= (ip_q == 3'd5) ? 3'd0 : ip_q + 3'd1;
				cp_q <= cp_adv[4:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ohc_checker.sv =====
`default_nettype none
module ohc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [9:0]  cfg_data,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one frame at a time: no transaction right after an accepted one
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// no result appears in the cycle after an input transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result without processing time");

	// gain register always writable
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind oversampled_hard_clipper ohc_checker u_ohc_checker (.*);
`default_nettype wire
